>>> rtl/dhcpc_pkg.sv
// Shared types and constants for the DHCP client lease controller.
`timescale 1ns / 1ps

package dhcpc_pkg;

	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC          = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCOVER_WAIT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_WAIT     = 2'd2;

	localparam logic [31:0] DISCOVER_WAIT_RST = 32'd10000000;
	localparam logic [31:0] REQUEST_WAIT_RST  = 32'd10000000;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_TIMER = 2'd1;
	localparam logic [1:0] KIND_FRAME = 2'd2;

	localparam logic [47:0] BCAST_MAC = 48'hffff_ffff_ffff;
	localparam logic [15:0] ETH_IPV4  = 16'h0800;
	localparam logic [7:0]  PROTO_UDP = 8'd17;
	localparam logic [7:0]  OP_REPLY  = 8'd2;
	localparam logic [7:0]  MSG_NONE  = 8'd0;
	localparam logic [7:0]  MSG_OFFER = 8'd2;
	localparam logic [7:0]  MSG_ACK   = 8'd5;

	localparam logic [11:0] MAX_WAIT_SEC = 12'd3600;
	localparam logic [19:0] US_PER_SEC   = 20'd1000000;

	typedef enum logic [1:0] {
		SEND_NONE     = 2'd0,
		SEND_DISCOVER = 2'd1,
		SEND_REQUEST  = 2'd2
	} send_t;

	typedef enum logic [3:0] {
		DROP_NONE       = 4'd0,
		DROP_MAC        = 4'd1,
		DROP_TYPE       = 4'd2,
		DROP_PROTO      = 4'd3,
		DROP_PORTS      = 4'd4,
		DROP_OP         = 4'd5,
		DROP_CHADDR     = 4'd6,
		DROP_OPTION     = 4'd7,
		DROP_WRONG_MSG  = 4'd8,
		DROP_UNEXPECTED = 4'd9
	} drop_t;

	typedef struct packed {
		drop_t drop;
		logic  is_offer;
		logic  is_ack;
	} frame_chk_t;

endpackage

>>> rtl/dhcpc_filter.sv
// Header filter for received frames: first failing check sets the drop reason.
`timescale 1ns / 1ps

module dhcpc_filter (
	input  logic [47:0]            own_mac,
	input  logic [47:0]            dest_mac,
	input  logic [15:0]            ether_type,
	input  logic [7:0]             ip_proto,
	input  logic                   ports_are_dhcp,
	input  logic [7:0]             bootp_op,
	input  logic [47:0]            chaddr,
	input  logic [7:0]             msg_type,
	output dhcpc_pkg::frame_chk_t  chk
);

	always_comb begin
		chk.is_offer = (msg_type == dhcpc_pkg::MSG_OFFER);
		chk.is_ack   = (msg_type == dhcpc_pkg::MSG_ACK);
		if (dest_mac != own_mac && dest_mac != dhcpc_pkg::BCAST_MAC) begin
			chk.drop = dhcpc_pkg::DROP_MAC;
		end else if (ether_type != dhcpc_pkg::ETH_IPV4) begin
			chk.drop = dhcpc_pkg::DROP_TYPE;
		end else if (ip_proto != dhcpc_pkg::PROTO_UDP) begin
			chk.drop = dhcpc_pkg::DROP_PROTO;
		end else if (!ports_are_dhcp) begin
			chk.drop = dhcpc_pkg::DROP_PORTS;
		end else if (bootp_op != dhcpc_pkg::OP_REPLY) begin
			chk.drop = dhcpc_pkg::DROP_OP;
		end else if (chaddr != own_mac) begin
			chk.drop = dhcpc_pkg::DROP_CHADDR;
		end else if (msg_type == dhcpc_pkg::MSG_NONE) begin
			chk.drop = dhcpc_pkg::DROP_OPTION;
		end else begin
			chk.drop = dhcpc_pkg::DROP_NONE;
		end
	end

endmodule

>>> rtl/dhcp_client_lease_fsm.sv
// Top level of the DHCP client lease controller: event register, lease FSM, result register.
`timescale 1ns / 1ps

// DHCP client lease state machine (idle, select, request, bound, renew, rebind). Each
// accepted event (start, timer expiry or a received frame as pre-parsed header fields)
// yields exactly one result: message to send, optional timer reload in microseconds,
// drop reason and the state after the event. One event is accepted every cycle unless
// the output stalls; the result passes through the event register and then the
// result register, with the state update and the lease timeout
// (lease >> 1 or >> 2, capped at 3600 s, times 1000000, one 12x20 multiply) done
// between them. Output stall holds the result register and, through it, the event
// register. Configuration writes are always ready and must be issued only while the
// block is empty. No clearing pass is needed after reset.

module dhcp_client_lease_fsm (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dhcpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                     cfg_data,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      kind,
	input  logic [47:0]                     dest_mac,
	input  logic [15:0]                     ether_type,
	input  logic [7:0]                      ip_proto,
	input  logic                            ports_are_dhcp,
	input  logic [7:0]                      bootp_op,
	input  logic [47:0]                     chaddr,
	input  logic [7:0]                      msg_type,
	input  logic                            needed_options_ok,
	input  logic [31:0]                     lease_seconds_in,
	input  logic [31:0]                     server_id,
	input  logic [31:0]                     offered_addr,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      send_type,
	output logic [31:0]                     send_client_ip,
	output logic [31:0]                     send_server_ip,
	output logic [31:0]                     send_requested_ip,
	output logic                            with_request_options,
	output logic                            timer_load,
	output logic [31:0]                     timer_us,
	output logic [3:0]                      drop_code,
	output logic                            forget_config,
	output logic                            apply_config,
	output logic [2:0]                      state_now
);

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_SELECT  = 3'd1,
		ST_REQUEST = 3'd2,
		ST_BOUND   = 3'd3,
		ST_RENEW   = 3'd4,
		ST_REBIND  = 3'd5
	} state_t;

	// configuration
	logic [47:0] own_mac_q;
	logic [31:0] discover_wait_q;
	logic [31:0] request_wait_q;

	// event register
	logic        s1_valid_q;
	logic [1:0]  kind_s1;
	logic [47:0] dest_mac_s1;
	logic [15:0] ether_type_s1;
	logic [7:0]  ip_proto_s1;
	logic        ports_are_dhcp_s1;
	logic [7:0]  bootp_op_s1;
	logic [47:0] chaddr_s1;
	logic [7:0]  msg_type_s1;
	logic        needed_options_ok_s1;
	logic [31:0] lease_seconds_in_s1;
	logic [31:0] server_id_s1;
	logic [31:0] offered_addr_s1;

	// lease state
	state_t      state_q;
	logic [31:0] lease_q;
	logic [31:0] bound_q;

	// result register
	logic                out_valid_q;
	dhcpc_pkg::send_t    send_type_s2;
	logic [31:0]         send_client_ip_s2;
	logic [31:0]         send_server_ip_s2;
	logic [31:0]         send_requested_ip_s2;
	logic                with_request_options_s2;
	logic                timer_load_s2;
	logic [31:0]         timer_us_s2;
	dhcpc_pkg::drop_t    drop_s2;
	logic                forget_s2;
	logic                apply_s2;
	state_t              state_s2;

	logic in_xfer;
	logic s2_load;
	logic s1_go;

	dhcpc_pkg::frame_chk_t chk;

	logic [31:0] wait_sec;
	logic [11:0] wait_capped;
	logic [31:0] wait_us;

	state_t              state_n;
	logic [31:0]         lease_n;
	logic [31:0]         bound_n;
	dhcpc_pkg::send_t    send_n;
	logic [31:0]         cip_n;
	logic [31:0]         sip_n;
	logic [31:0]         rip_n;
	logic                wopt_n;
	logic                tload_n;
	logic [31:0]         tus_n;
	dhcpc_pkg::drop_t    drop_n;
	logic                forget_n;
	logic                apply_n;

	assign cfg_ready = 1'b1;

	assign s2_load  = !out_valid_q || !out_stall;
	assign s1_go    = s1_valid_q && s2_load;
	assign in_stall = s1_valid_q && !s2_load;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q       <= '0;
			discover_wait_q <= dhcpc_pkg::DISCOVER_WAIT_RST;
			request_wait_q  <= dhcpc_pkg::REQUEST_WAIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dhcpc_pkg::CFG_OWN_MAC:       own_mac_q       <= cfg_data[47:0];
				dhcpc_pkg::CFG_DISCOVER_WAIT: discover_wait_q <= cfg_data[31:0];
				dhcpc_pkg::CFG_REQUEST_WAIT:  request_wait_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_xfer) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_s1              <= kind;
			dest_mac_s1          <= dest_mac;
			ether_type_s1        <= ether_type;
			ip_proto_s1          <= ip_proto;
			ports_are_dhcp_s1    <= ports_are_dhcp;
			bootp_op_s1          <= bootp_op;
			chaddr_s1            <= chaddr;
			msg_type_s1          <= msg_type;
			needed_options_ok_s1 <= needed_options_ok;
			lease_seconds_in_s1  <= lease_seconds_in;
			server_id_s1         <= server_id;
			offered_addr_s1      <= offered_addr;
		end
	end

	dhcpc_filter u_filter (
		.own_mac        (own_mac_q),
		.dest_mac       (dest_mac_s1),
		.ether_type     (ether_type_s1),
		.ip_proto       (ip_proto_s1),
		.ports_are_dhcp (ports_are_dhcp_s1),
		.bootp_op       (bootp_op_s1),
		.chaddr         (chaddr_s1),
		.msg_type       (msg_type_s1),
		.chk            (chk)
	);

	// an ACK times on the new lease / 2, a timer re-request on the stored lease / 4
	assign wait_sec    = (kind_s1 == dhcpc_pkg::KIND_FRAME) ? (lease_seconds_in_s1 >> 1)
	                                                          : (lease_q >> 2);
	assign wait_capped = (wait_sec > 32'(dhcpc_pkg::MAX_WAIT_SEC)) ? dhcpc_pkg::MAX_WAIT_SEC
	                                                              : wait_sec[11:0];
	assign wait_us     = 32'(wait_capped) * 32'(dhcpc_pkg::US_PER_SEC);

	always_comb begin
		state_n  = state_q;
		lease_n  = lease_q;
		bound_n  = bound_q;
		send_n   = dhcpc_pkg::SEND_NONE;
		cip_n    = '0;
		sip_n    = '0;
		rip_n    = '0;
		wopt_n   = 1'b0;
		tload_n  = 1'b0;
		tus_n    = '0;
		drop_n   = dhcpc_pkg::DROP_NONE;
		forget_n = 1'b0;
		apply_n  = 1'b0;
		unique case (kind_s1)
			dhcpc_pkg::KIND_START: begin
				state_n = ST_SELECT;
				send_n  = dhcpc_pkg::SEND_DISCOVER;
				tload_n = 1'b1;
				tus_n   = discover_wait_q;
			end
			dhcpc_pkg::KIND_TIMER: begin
				unique case (state_q) inside
					ST_BOUND, ST_RENEW: begin
						state_n = (state_q == ST_BOUND) ? ST_RENEW : ST_REBIND;
						send_n  = dhcpc_pkg::SEND_REQUEST;
						cip_n   = bound_q;
						rip_n   = bound_q;
						tload_n = 1'b1;
						tus_n   = wait_us;
					end
					default: begin
						// rebind expiry drops the address, then rediscover
						if (state_q == ST_REBIND) begin
							forget_n = 1'b1;
							bound_n  = '0;
						end
						state_n = ST_SELECT;
						send_n  = dhcpc_pkg::SEND_DISCOVER;
						tload_n = 1'b1;
						tus_n   = discover_wait_q;
					end
				endcase
			end
			dhcpc_pkg::KIND_FRAME: begin
				if (chk.drop != dhcpc_pkg::DROP_NONE) begin
					drop_n = chk.drop;
				end else begin
					unique case (state_q) inside
						ST_SELECT: begin
							if (!chk.is_offer) begin
								drop_n = dhcpc_pkg::DROP_WRONG_MSG;
							end else if (!needed_options_ok_s1) begin
								drop_n = dhcpc_pkg::DROP_OPTION;
							end else begin
								state_n = ST_REQUEST;
								send_n  = dhcpc_pkg::SEND_REQUEST;
								sip_n   = server_id_s1;
								rip_n   = offered_addr_s1;
								wopt_n  = 1'b1;
								tload_n = 1'b1;
								tus_n   = request_wait_q;
							end
						end
						ST_REQUEST, ST_RENEW, ST_REBIND: begin
							if (!chk.is_ack) begin
								drop_n = dhcpc_pkg::DROP_WRONG_MSG;
							end else if (!needed_options_ok_s1) begin
								drop_n = dhcpc_pkg::DROP_OPTION;
							end else begin
								lease_n = lease_seconds_in_s1;
								state_n = ST_BOUND;
								tload_n = 1'b1;
								tus_n   = wait_us;
								// first ACK binds the address; renew and rebind keep it
								if (state_q == ST_REQUEST) begin
									bound_n = offered_addr_s1;
									apply_n = 1'b1;
								end
							end
						end
						default: drop_n = dhcpc_pkg::DROP_UNEXPECTED;
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q                 <= ST_IDLE;
			lease_q                 <= '0;
			bound_q                 <= '0;
			out_valid_q             <= 1'b0;
			send_type_s2            <= dhcpc_pkg::SEND_NONE;
			send_client_ip_s2       <= '0;
			send_server_ip_s2       <= '0;
			send_requested_ip_s2    <= '0;
			with_request_options_s2 <= 1'b0;
			timer_load_s2           <= 1'b0;
			timer_us_s2             <= '0;
			drop_s2                 <= dhcpc_pkg::DROP_NONE;
			forget_s2               <= 1'b0;
			apply_s2                <= 1'b0;
			state_s2                <= ST_IDLE;
		end else begin
			if (s2_load) begin
				out_valid_q <= s1_valid_q;
			end
			if (s1_go) begin
				state_q                 <= state_n;
				lease_q                 <= lease_n;
				bound_q                 <= bound_n;
				send_type_s2            <= send_n;
				send_client_ip_s2       <= cip_n;
				send_server_ip_s2       <= sip_n;
				send_requested_ip_s2    <= rip_n;
				with_request_options_s2 <= wopt_n;
				timer_load_s2           <= tload_n;
				timer_us_s2             <= tus_n;
				drop_s2                 <= drop_n;
				forget_s2               <= forget_n;
				apply_s2                <= apply_n;
				state_s2                <= state_n;
			end
		end
	end

	assign out_valid            = out_valid_q;
	assign send_type            = send_type_s2;
	assign send_client_ip       = send_client_ip_s2;
	assign send_server_ip       = send_server_ip_s2;
	assign send_requested_ip    = send_requested_ip_s2;
	assign with_request_options = with_request_options_s2;
	assign timer_load           = timer_load_s2;
	assign timer_us             = timer_us_s2;
	assign drop_code            = drop_s2;
	assign forget_config        = forget_s2;
	assign apply_config         = apply_s2;
	assign state_now            = state_s2;

`ifndef SYNTHESIS
	a_apply_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && apply_config |-> state_now == ST_BOUND && timer_load &&
		drop_code == dhcpc_pkg::DROP_NONE)
		else $error("apply_config without a bound state and timer reload");

	a_forget_discover: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && forget_config |-> send_type == dhcpc_pkg::SEND_DISCOVER &&
		state_now == ST_SELECT)
		else $error("forget_config without a discover");

	a_opts_request: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && with_request_options |-> send_type == dhcpc_pkg::SEND_REQUEST &&
		state_now == ST_REQUEST)
		else $error("request options outside a request after offer");

	a_timer_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !timer_load |-> timer_us == '0 && send_type == dhcpc_pkg::SEND_NONE)
		else $error("timer value or send without a timer reload");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q && out_valid_q && out_stall)
		else $error("input stalled while the event register can advance");
`endif

endmodule
